@@ rtl/rcle_pkg.sv @@
`timescale 1ns / 1ps

package rcle_pkg;

  // Alphabet and wheel set
  localparam int unsigned LETTERS     = 26;
  localparam int unsigned WHEEL_COUNT = 5;
  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned SEL_W       = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 60;
  localparam int unsigned PLUG_W      = 60;
  localparam int unsigned PLUG_HI_W   = 10;
  localparam int unsigned PLUG_ALL_W  = 2 * PLUG_W + PLUG_HI_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_SEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUG_LO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUG_MID   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUG_HI    = 3'd6;

  // Wheel wiring, entry side to exit side (wheels I to V)
  localparam int unsigned WHEEL_FWD [WHEEL_COUNT][LETTERS] = '{
    '{4,10,12,5,11,6,3,16,21,25,13,19,14,22,24,7,23,20,18,15,0,8,1,17,2,9},
    '{0,9,3,10,18,8,17,20,23,1,11,7,22,19,12,2,16,6,25,13,15,24,5,21,14,4},
    '{1,3,5,7,9,11,2,15,17,19,23,21,25,13,24,4,8,22,6,0,10,12,20,18,16,14},
    '{4,18,14,21,15,25,9,0,24,16,20,8,17,7,23,11,13,5,19,6,10,3,2,12,22,1},
    '{21,25,1,17,6,8,19,24,20,15,18,3,13,7,11,23,0,22,12,9,16,14,5,4,2,10}
  };

  // Inverse wiring, exit side back to entry side
  localparam int unsigned WHEEL_BWD [WHEEL_COUNT][LETTERS] = '{
    '{20,22,24,6,0,3,5,15,21,25,1,4,2,10,12,19,7,23,18,11,17,8,13,16,14,9},
    '{0,9,15,2,25,22,17,11,5,1,3,10,14,19,24,20,16,6,4,13,7,23,12,8,21,18},
    '{19,0,6,1,15,2,18,3,16,4,20,5,21,13,25,7,24,8,23,9,22,11,17,10,14,12},
    '{7,25,22,21,0,17,19,13,11,6,20,15,23,16,2,4,9,12,1,18,10,3,24,14,8,5},
    '{16,2,24,11,23,22,4,13,5,19,25,14,18,12,21,9,20,3,10,6,8,0,17,15,7,1}
  };

  // Turnover positions Q, E, V, J, Z
  localparam int unsigned NOTCH [WHEEL_COUNT] = '{16, 4, 21, 9, 25};

  // Reflector B
  localparam int unsigned REFLECTOR [LETTERS] = '{
    24,17,20,7,16,18,11,3,15,23,13,6,14,10,12,8,4,1,5,25,2,22,21,9,0,19
  };

  // Operation of the shared substitution unit
  typedef enum logic [1:0] {
    SUB_PLUG,
    SUB_FWD,
    SUB_BWD,
    SUB_REFL
  } sub_op_e;

  // Wheel slot used by a pass
  typedef enum logic [1:0] {
    SLOT_RIGHT,
    SLOT_MIDDLE,
    SLOT_LEFT
  } slot_e;

  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter_in;
    logic [LETTER_W-1:0] load_right_pos;
    logic [LETTER_W-1:0] load_middle_pos;
    logic [LETTER_W-1:0] load_left_pos;
  } in_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_out;
    logic [LETTER_W-1:0] right_pos_now;
    logic [LETTER_W-1:0] middle_pos_now;
    logic [LETTER_W-1:0] left_pos_now;
  } out_item_t;

  typedef struct packed {
    logic    accept;
    logic    step;
    logic    sub_en;
    sub_op_e sub_op;
    slot_e   slot;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic can_run;
  } dp_status_t;

  // Modulo 26 helpers; operands are already below 26
  function automatic logic [LETTER_W-1:0] add_mod26(logic [LETTER_W-1:0] a,
                                                    logic [LETTER_W-1:0] b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(LETTERS)) s = s - 6'(LETTERS);
    return s[LETTER_W-1:0];
  endfunction

  function automatic logic [LETTER_W-1:0] sub_mod26(logic [LETTER_W-1:0] a,
                                                    logic [LETTER_W-1:0] b);
    logic [LETTER_W:0] t;
    if (a >= b) t = {1'b0, a} - {1'b0, b};
    else        t = {1'b0, a} + 6'(LETTERS) - {1'b0, b};
    return t[LETTER_W-1:0];
  endfunction

  function automatic logic [LETTER_W-1:0] inc_mod26(logic [LETTER_W-1:0] a);
    return (a == 5'(LETTERS - 1)) ? '0 : a + 5'd1;
  endfunction

  // Fold a loaded position of 26..31 back into range
  function automatic logic [LETTER_W-1:0] reduce_pos(logic [LETTER_W-1:0] p);
    return (p >= 5'(LETTERS)) ? p - 5'(LETTERS) : p;
  endfunction

endpackage

@@ rtl/rcle_if.sv @@
`timescale 1ns / 1ps

// Request channel into the engine
interface rcle_in_if import rcle_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// Result channel out of the engine
interface rcle_out_if import rcle_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

@@ rtl/rcle_datapath.sv @@
`timescale 1ns / 1ps

module rcle_datapath import rcle_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_item_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output out_item_t             out_item_o
);

  logic                  enable_q;
  logic [SEL_W-1:0]      right_sel_q, middle_sel_q, left_sel_q;
  logic [PLUG_W-1:0]     plug_lo_q, plug_mid_q;
  logic [PLUG_HI_W-1:0]  plug_hi_q;

  logic [LETTER_W-1:0]   right_pos_q, middle_pos_q, left_pos_q;
  logic [LETTER_W-1:0]   right_pos_d, middle_pos_d, left_pos_d;
  logic [LETTER_W-1:0]   c_q, c_d;
  out_item_t             out_q;

  logic [PLUG_ALL_W-1:0] plug_all;
  logic [LETTER_W-1:0]   plug_ent [LETTERS];
  logic [LETTER_W-1:0]   plug_e, plug_res;
  logic                  mid_at, right_at;
  logic [SEL_W-1:0]      wheel;
  logic [LETTER_W-1:0]   pos;
  logic [LETTER_W-1:0]   entry, fwd_y, bwd_y, sub_res;
  logic                  sels_ok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      right_sel_q  <= 3'd0;
      middle_sel_q <= 3'd1;
      left_sel_q   <= 3'd2;
      plug_lo_q    <= '0;
      plug_mid_q   <= '0;
      plug_hi_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:     enable_q     <= cfg_data_i[0];
        CFG_RIGHT_SEL:  right_sel_q  <= cfg_data_i[SEL_W-1:0];
        CFG_MIDDLE_SEL: middle_sel_q <= cfg_data_i[SEL_W-1:0];
        CFG_LEFT_SEL:   left_sel_q   <= cfg_data_i[SEL_W-1:0];
        CFG_PLUG_LO:    plug_lo_q    <= cfg_data_i[PLUG_W-1:0];
        CFG_PLUG_MID:   plug_mid_q   <= cfg_data_i[PLUG_W-1:0];
        CFG_PLUG_HI:    plug_hi_q    <= cfg_data_i[PLUG_HI_W-1:0];
        default: ;
      endcase
    end
  end

  // Decide whether the offered request runs the full cipher path
  assign sels_ok = (right_sel_q < 3'(WHEEL_COUNT)) && (middle_sel_q < 3'(WHEEL_COUNT))
                && (left_sel_q < 3'(WHEEL_COUNT));
  assign status_o.can_run = !in_item_i.kind && enable_q && sels_ok
                         && (in_item_i.letter_in < 5'(LETTERS));

  // Stepping with the middle wheel double step
  assign mid_at   = (middle_pos_q == 5'(NOTCH[middle_sel_q]));
  assign right_at = (right_pos_q == 5'(NOTCH[right_sel_q]));

  always_comb begin
    right_pos_d  = right_pos_q;
    middle_pos_d = middle_pos_q;
    left_pos_d   = left_pos_q;
    if (cmd_i.accept && in_item_i.kind) begin
      right_pos_d  = reduce_pos(in_item_i.load_right_pos);
      middle_pos_d = reduce_pos(in_item_i.load_middle_pos);
      left_pos_d   = reduce_pos(in_item_i.load_left_pos);
    end else if (cmd_i.step) begin
      right_pos_d = inc_mod26(right_pos_q);
      if (mid_at) begin
        middle_pos_d = inc_mod26(middle_pos_q);
        left_pos_d   = inc_mod26(left_pos_q);
      end else if (right_at) begin
        middle_pos_d = inc_mod26(middle_pos_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_pos_q  <= '0;
      middle_pos_q <= '0;
      left_pos_q   <= '0;
    end else begin
      right_pos_q  <= right_pos_d;
      middle_pos_q <= middle_pos_d;
      left_pos_q   <= left_pos_d;
    end
  end

  // Plugboard entries, five bits per letter
  assign plug_all = {plug_hi_q, plug_mid_q, plug_lo_q};

  always_comb begin
    for (int i = 0; i < LETTERS; i++) begin
      plug_ent[i] = plug_all[i*LETTER_W +: LETTER_W];
    end
  end

  assign plug_e   = plug_ent[c_q];
  assign plug_res = (plug_e == '0 || plug_e > 5'(LETTERS)) ? c_q : plug_e - 5'd1;

  // Pick the wheel and position of the active slot
  always_comb begin
    case (cmd_i.slot)
      SLOT_MIDDLE: begin
        wheel = middle_sel_q;
        pos   = middle_pos_q;
      end
      SLOT_LEFT: begin
        wheel = left_sel_q;
        pos   = left_pos_q;
      end
      default: begin
        wheel = right_sel_q;
        pos   = right_pos_q;
      end
    endcase
  end

  // Shared substitution unit: one pass per cycle
  assign entry = add_mod26(c_q, pos);
  assign fwd_y = sub_mod26(5'(WHEEL_FWD[wheel][entry]), pos);
  assign bwd_y = sub_mod26(5'(WHEEL_BWD[wheel][entry]), pos);

  always_comb begin
    case (cmd_i.sub_op)
      SUB_PLUG: sub_res = plug_res;
      SUB_FWD:  sub_res = fwd_y;
      SUB_BWD:  sub_res = bwd_y;
      default:  sub_res = 5'(REFLECTOR[c_q]);
    endcase
  end

  // Working letter: take the request letter, then each pass result
  always_comb begin
    c_d = c_q;
    if (cmd_i.accept)      c_d = in_item_i.letter_in;
    else if (cmd_i.sub_en) c_d = sub_res;
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.letter_out     <= c_q;
      out_q.right_pos_now  <= right_pos_q;
      out_q.middle_pos_now <= middle_pos_q;
      out_q.left_pos_now   <= left_pos_q;
    end
  end

  assign out_item_o = out_q;

endmodule

@@ rtl/rcle_ctrl.sv @@
`timescale 1ns / 1ps

module rcle_ctrl import rcle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int unsigned PASS_W = 4;
  localparam logic [PASS_W-1:0] PASS_LAST = 4'd8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STEP = 2'd1;
  localparam logic [1:0] S_PASS = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic              out_valid_q, out_valid_d;
  logic              accept, out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Pass sequence: plug, right, middle, left, reflect, left, middle, right, plug
  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.step     = (state_q == S_STEP);
    cmd_o.sub_en   = (state_q == S_PASS);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
    unique case (pass_q)
      4'd0: begin cmd_o.sub_op = SUB_PLUG; cmd_o.slot = SLOT_RIGHT;  end
      4'd1: begin cmd_o.sub_op = SUB_FWD;  cmd_o.slot = SLOT_RIGHT;  end
      4'd2: begin cmd_o.sub_op = SUB_FWD;  cmd_o.slot = SLOT_MIDDLE; end
      4'd3: begin cmd_o.sub_op = SUB_FWD;  cmd_o.slot = SLOT_LEFT;   end
      4'd4: begin cmd_o.sub_op = SUB_REFL; cmd_o.slot = SLOT_LEFT;   end
      4'd5: begin cmd_o.sub_op = SUB_BWD;  cmd_o.slot = SLOT_LEFT;   end
      4'd6: begin cmd_o.sub_op = SUB_BWD;  cmd_o.slot = SLOT_MIDDLE; end
      4'd7: begin cmd_o.sub_op = SUB_BWD;  cmd_o.slot = SLOT_RIGHT;  end
      default: begin cmd_o.sub_op = SUB_PLUG; cmd_o.slot = SLOT_RIGHT; end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = status_i.can_run ? S_STEP : S_DONE;
      end
      S_STEP: begin
        state_d = S_PASS;
        pass_d  = '0;
      end
      S_PASS: begin
        if (pass_q == PASS_LAST) state_d = S_DONE;
        else                     pass_d  = pass_q + 4'd1;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result valid until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)  out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/rotor_cipher_letter_engine.sv @@
`timescale 1ns / 1ps

// Three-wheel rotor cipher, reflector B, plugboard, one letter per request.
// in_i carries requests: kind 0 enciphers letter_in, kind 1 loads the three
// wheel positions (26..31 fold down by 26). out_o returns one result per
// request: the letter (unchanged for loads, when disabled, when a wheel choice
// is not I to V, or out of range) and the wheel positions after the request.
// cfg_we_i/cfg_idx_i/cfg_data_i write the enable, wheel choices and plug map;
// write only while no request is in flight.
// An enciphered letter goes through the accept, a stepping state, nine
// passes through the single shared substitution unit (plug, three wheels
// forward, reflector, three wheels back, plug) and a state handing the
// result to the output register; a new request is accepted only after that.
// Loads and pass-through letters go from the accept straight to the hand-off
// state. The result is offered from the output register once the hand-off
// has loaded it.
// The output register keeps a result while the receiver stalls; the next
// request is accepted and worked on meanwhile, and only its hand-off waits.
// Reset clears the positions to A, disables the engine, selects wheels
// I, II, III and empties the plugboard.
module rotor_cipher_letter_engine import rcle_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rcle_in_if.sink               in_i,
  rcle_out_if.source            out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready, out_valid;
  out_item_t  out_item;

  rcle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rcle_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_i.item),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.item  = out_item;

`ifndef NO_ASSERTIONS
  // No pass or step runs while a new request can be taken
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !cmd.sub_en && !cmd.step)
    else $error("datapath busy while accepting requests");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid || out_o.ready))
    else $error("result register overwritten");

  // Stepping is followed by the entry plugboard pass
  a_step_then_plug: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |=> cmd.sub_en && cmd.sub_op == SUB_PLUG)
    else $error("pass sequence does not start after stepping");

  // Reported positions stay on the wheel
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_item.right_pos_now < 5'(LETTERS))
               && (out_item.middle_pos_now < 5'(LETTERS))
               && (out_item.left_pos_now < 5'(LETTERS)))
    else $error("wheel position out of range");
`endif

endmodule
